>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Each use expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Types and constants of the threshold sweep autocalibrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsa_pkg;

	localparam int unsigned TH_W = 12;
	localparam int unsigned SW_W = 13;
	localparam logic [TH_W-1:0] TH_MAX = 12'hFFF;

	typedef enum logic [1:0] {
		OP_FRAME   = 2'd0,
		OP_START   = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		PH_INIT   = 2'd0,
		PH_READER = 2'd1,
		PH_CARD   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_OK      = 2'd1,
		ST_NO_GOOD = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]      op;
		logic            from_card;
		logic            crc_ok;
		logic [TH_W-1:0] current_threshold;
		logic [TH_W-1:0] noise_level;
	} item_t;

	typedef struct packed {
		logic [TH_W-1:0] threshold;
		logic            threshold_write;
		logic            finished;
		logic [1:0]      status;
	} result_t;

endpackage

>>> rtl/core/tsa_in_if.sv
// ----------------------------------------------------------------------------
// tsa_in_if
// Valid/ready channel carrying one sniffed event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsa_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic        from_card;
	logic        crc_ok;
	logic [11:0] current_threshold;
	logic [11:0] noise_level;

	modport source (
		output valid, op, from_card, crc_ok, current_threshold, noise_level,
		input  ready
	);
	modport sink (
		input  valid, op, from_card, crc_ok, current_threshold, noise_level,
		output ready
	);
endinterface

>>> rtl/core/tsa_out_if.sv
// ----------------------------------------------------------------------------
// tsa_out_if
// Valid/ready channel carrying one calibration result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsa_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] threshold;
	logic        threshold_write;
	logic        finished;
	logic [1:0]  status;

	modport source (
		output valid, threshold, threshold_write, finished, status,
		input  ready
	);
	modport sink (
		input  valid, threshold, threshold_write, finished, status,
		output ready
	);
endinterface

>>> rtl/core/tsa_engine.sv
// ----------------------------------------------------------------------------
// tsa_engine
// Calibration state and the per-event compare-and-add logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_engine #(
	parameter int unsigned SWEEP_STEP = 50
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tsa_pkg::item_t  item,
	output tsa_pkg::result_t res
);
	import tsa_pkg::*;

	localparam logic [SW_W-1:0] STEP = SW_W'(SWEEP_STEP);

	logic            armed_q, armed_d;
	phase_t          phase_q, phase_d;
	logic [SW_W-1:0] sweep_q, sweep_d;
	logic [SW_W-1:0] top_q, top_d;
	logic [TH_W-1:0] first_q, first_d;
	logic [TH_W-1:0] last_q, last_d;
	logic [TH_W-1:0] saved_q, saved_d;
	logic            round_good_q, round_good_d;

	logic [SW_W-1:0] lo, hi, fn_ext, cur_ext, sweep_inc, mid_sum;
	logic [TH_W-1:0] back_off;
	logic            do_step;
	logic            good_card;

	always_comb begin
		fn_ext    = {1'b0, item.noise_level};
		cur_ext   = {1'b0, item.current_threshold};
		lo        = fn_ext >> 1;
		hi        = fn_ext + (fn_ext >> 1);
		sweep_inc = sweep_q + STEP;
		back_off  = (cur_ext >= STEP) ? TH_W'(cur_ext - STEP) : '0;
		mid_sum   = '0;
		good_card = item.from_card && item.crc_ok;

		armed_d      = armed_q;
		phase_d      = phase_q;
		sweep_d      = sweep_q;
		top_d        = top_q;
		first_d      = first_q;
		last_d       = last_q;
		saved_d      = saved_q;
		round_good_d = round_good_q;
		do_step      = 1'b0;
		res          = '0;

		case (item.op)
			OP_START: begin
				armed_d = 1'b1;
				phase_d = PH_INIT;
			end
			OP_TIMEOUT: begin
				res.threshold       = saved_q;
				res.threshold_write = 1'b1;
				armed_d             = 1'b0;
				phase_d             = PH_INIT;
			end
			OP_FRAME: begin
				if (armed_q) begin
					case (phase_q)
						PH_INIT: begin
							// empty range only when the floor noise is zero
							if (lo >= hi) begin
								sweep_d = '0;
								top_d   = {1'b0, TH_MAX};
							end else begin
								sweep_d = lo;
								top_d   = hi;
							end
							first_d             = '0;
							last_d              = TH_MAX;
							saved_d             = item.current_threshold;
							round_good_d        = 1'b0;
							res.threshold       = (lo >= hi) ? '0 : TH_W'(lo);
							res.threshold_write = 1'b1;
							phase_d             = item.from_card ? PH_CARD : PH_READER;
						end
						PH_READER: begin
							do_step = 1'b1;
							if (!item.from_card) begin
								if (round_good_q)
									last_d = back_off;
								round_good_d = 1'b0;
							end else begin
								phase_d = PH_CARD;
							end
						end
						PH_CARD: begin
							if (item.from_card)
								do_step = 1'b1;
							else
								phase_d = PH_READER;
						end
						default: ;
					endcase

					// record the first good card frame of the sweep
					if (do_step && good_card) begin
						if (first_q == '0)
							first_d = item.current_threshold;
						round_good_d = 1'b1;
					end

					if (do_step) begin
						sweep_d             = sweep_inc;
						res.threshold       = (sweep_inc > {1'b0, TH_MAX}) ? TH_MAX
							: TH_W'(sweep_inc);
						res.threshold_write = 1'b1;
						if (sweep_inc >= top_q) begin
							// use the first and last good values as updated by this beat
							if (first_d != '0) begin
								mid_sum       = {1'b0, first_d} + {1'b0, last_d};
								res.threshold = TH_W'(mid_sum >> 1);
								res.status    = ST_OK;
							end else begin
								res.threshold = saved_q;
								res.status    = ST_NO_GOOD;
							end
							res.finished = 1'b1;
							armed_d      = 1'b0;
							phase_d      = PH_INIT;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			phase_q      <= PH_INIT;
			sweep_q      <= '0;
			top_q        <= {1'b0, TH_MAX};
			first_q      <= '0;
			last_q       <= TH_MAX;
			saved_q      <= '0;
			round_good_q <= 1'b0;
		end else if (en) begin
			armed_q      <= armed_d;
			phase_q      <= phase_d;
			sweep_q      <= sweep_d;
			top_q        <= top_d;
			first_q      <= first_d;
			last_q       <= last_d;
			saved_q      <= saved_d;
			round_good_q <= round_good_d;
		end
	end

endmodule

>>> rtl/core/threshold_sweep_autocalibrator_unit.sv
// ----------------------------------------------------------------------------
// threshold_sweep_autocalibrator_unit
// Sweeps a demodulator threshold over sniffed frames and picks the midpoint.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : one event per beat (frame seen, start calibration, timeout),
//            with the frame source, CRC flag, threshold in effect and the
//            measured floor noise.
//   result : exactly one beat per frame beat, in order: the threshold to
//            apply, its write strobe, the end-of-calibration flag and status.
//   An accepted frame beat passes the input register, then the state update
//   and result register. Throughput is one beat per cycle unless the result
//   receiver stalls; combinational compare-and-add logic updates the
//   calibration state, so consecutive beats need no gaps.
//   Reset disarms the calibrator and restores the default sweep range.
//   When the result receiver stalls, the result register holds its beat, the
//   input register holds the next one, and frame.ready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module threshold_sweep_autocalibrator_unit #(
	parameter int unsigned SWEEP_STEP = 50
) (
	input  logic      clk,
	input  logic      arst_n,
	tsa_in_if.sink    frame,
	tsa_out_if.source result
);
	import tsa_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_d;
	logic    stall;
	logic    adv;

	assign stall       = valid_s2 && !result.ready;
	assign adv         = valid_s1 && !stall;
	assign frame.ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (frame.ready)
			valid_s1 <= frame.valid;
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			item_s1.op                <= frame.op;
			item_s1.from_card         <= frame.from_card;
			item_s1.crc_ok            <= frame.crc_ok;
			item_s1.current_threshold <= frame.current_threshold;
			item_s1.noise_level       <= frame.noise_level;
		end
	end

	tsa_engine #(
		.SWEEP_STEP (SWEEP_STEP)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.res    (res_d)
	);

	// hold the result beat while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (!stall)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_d;
	end

	assign result.valid           = valid_s2;
	assign result.threshold       = res_s2.threshold;
	assign result.threshold_write = res_s2.threshold_write;
	assign result.finished        = res_s2.finished;
	assign result.status          = res_s2.status;

`include "assert_macros.svh"

	`ASSERT_IMP(a_fin_writes, valid_s2 && res_s2.finished, res_s2.threshold_write,
		"finished result without threshold write")
	`ASSERT_IMP(a_status_fin, valid_s2 && !res_s2.finished, res_s2.status == ST_NONE,
		"status reported on an unfinished result")
	`ASSERT_NXT(a_s1_held, valid_s1 && stall, valid_s1,
		"input stage dropped a beat during a stall")
	`ASSERT_NXT(a_s1_moves, adv, valid_s2,
		"advanced beat did not reach the result register")

endmodule

>>> test/tsa_calib_checker.sv
// ----------------------------------------------------------------------------
// tsa_calib_checker
// Watches both channels of the threshold sweep autocalibrator, predicts the
// result of every accepted frame beat and compares it field by field with
// the result beats that the block delivers, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_calib_checker
	import tsa_pkg::*;
#(
	parameter int unsigned SWEEP_STEP = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	tsa_in_if           frame,
	tsa_out_if          result,
	output int unsigned mismatches,
	output int unsigned pending
);

	// Predicted calibration state
	logic              cal_armed;
	phase_t            cal_phase;
	logic [SW_W-1:0]   sweep_th;
	logic [SW_W-1:0]   sweep_top;
	logic [SW_W-1:0]   first_good_th;
	logic [SW_W-1:0]   last_good_th;
	logic [TH_W-1:0]   saved_th;
	logic              round_had_good;

	result_t           expected_results[$];
	item_t             seen_item;
	result_t           want;
	result_t           got;
	result_t           calc;

	function automatic logic [TH_W-1:0] clip12(input logic [SW_W:0] v);
		return (v > {1'b0, {(SW_W-TH_W){1'b0}}, TH_MAX}) ? TH_MAX : v[TH_W-1:0];
	endfunction

	task automatic note_card_frame(input logic crc, input logic [TH_W-1:0] cur);
		if (crc) begin
			if (first_good_th == '0)
				first_good_th = {1'b0, cur};
			round_had_good = 1'b1;
		end
	endtask

	// Advance one step; end the calibration once the top is reached.
	task automatic advance_sweep(inout result_t r);
		logic [SW_W:0] mid_sum;
		sweep_th = sweep_th + SW_W'(SWEEP_STEP);
		r.threshold = clip12({1'b0, sweep_th});
		r.threshold_write = 1'b1;
		if (sweep_th >= sweep_top) begin
			if (first_good_th != '0) begin
				mid_sum = {1'b0, first_good_th} + {1'b0, last_good_th};
				r.threshold = clip12(mid_sum >> 1);
				r.status = ST_OK;
			end else begin
				r.threshold = saved_th;
				r.status = ST_NO_GOOD;
			end
			r.finished = 1'b1;
			cal_armed = 1'b0;
			cal_phase = PH_INIT;
		end
	endtask

	task automatic predict_calibration(input item_t it, output result_t r);
		logic [SW_W-1:0] lo;
		logic [SW_W-1:0] hi;
		r = '0;
		case (it.op)
			OP_START: begin
				cal_armed = 1'b1;
				cal_phase = PH_INIT;
			end
			OP_TIMEOUT: begin
				r.threshold = saved_th;
				r.threshold_write = 1'b1;
				cal_armed = 1'b0;
				cal_phase = PH_INIT;
			end
			OP_FRAME: begin
				if (cal_armed) begin
					case (cal_phase)
						PH_INIT: begin
							lo = {1'b0, it.noise_level >> 1};
							hi = {1'b0, it.noise_level} + {2'b0, it.noise_level[TH_W-1:1]};
							// Empty range: fall back to the full scale
							if (lo >= hi) begin
								lo = '0;
								hi = {1'b0, TH_MAX};
							end
							sweep_top = hi;
							first_good_th = '0;
							last_good_th = {1'b0, TH_MAX};
							saved_th = it.current_threshold;
							round_had_good = 1'b0;
							sweep_th = lo;
							r.threshold = clip12({1'b0, lo});
							r.threshold_write = 1'b1;
							cal_phase = it.from_card ? PH_CARD : PH_READER;
						end
						PH_READER: begin
							if (!it.from_card) begin
								// Missing card reply: back off from this threshold
								if (round_had_good)
									last_good_th = (it.current_threshold >= TH_W'(SWEEP_STEP)) ?
										{1'b0, it.current_threshold - TH_W'(SWEEP_STEP)} : '0;
								round_had_good = 1'b0;
							end else begin
								note_card_frame(it.crc_ok, it.current_threshold);
								cal_phase = PH_CARD;
							end
							advance_sweep(r);
						end
						PH_CARD: begin
							if (it.from_card) begin
								note_card_frame(it.crc_ok, it.current_threshold);
								advance_sweep(r);
							end else begin
								cal_phase = PH_READER;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_armed = 1'b0;
			cal_phase = PH_INIT;
			sweep_th = '0;
			sweep_top = {1'b0, TH_MAX};
			first_good_th = '0;
			last_good_th = {1'b0, TH_MAX};
			saved_th = '0;
			round_had_good = 1'b0;
			expected_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			// Compare before pushing: a beat accepted now cannot be answered yet
			if (result.valid && result.ready) begin
				got.threshold = result.threshold;
				got.threshold_write = result.threshold_write;
				got.finished = result.finished;
				got.status = result.status;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: threshold %0d write %0b",
						got.threshold, got.threshold_write);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.threshold !== want.threshold) begin
						$error("threshold: expected %0d, actual %0d", want.threshold,
							got.threshold);
						mismatches++;
					end
					if (got.threshold_write !== want.threshold_write) begin
						$error("threshold_write: expected %0b, actual %0b",
							want.threshold_write, got.threshold_write);
						mismatches++;
					end
					if (got.finished !== want.finished) begin
						$error("finished: expected %0b, actual %0b", want.finished,
							got.finished);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						mismatches++;
					end
				end
			end
			if (frame.valid && frame.ready) begin
				seen_item.op = frame.op;
				seen_item.from_card = frame.from_card;
				seen_item.crc_ok = frame.crc_ok;
				seen_item.current_threshold = frame.current_threshold;
				seen_item.noise_level = frame.noise_level;
				predict_calibration(seen_item, calc);
				expected_results.push_back(calc);
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> test/threshold_sweep_autocalibrator_unit_test.sv
// ----------------------------------------------------------------------------
// threshold_sweep_autocalibrator_unit_test
// Drives directed and random calibration sessions into the autocalibrator
// with random gaps and stalls on both channels; the checker predicts and
// compares every result beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module threshold_sweep_autocalibrator_unit_test;
	import tsa_pkg::*;

	localparam int unsigned STEP       = 50;
	localparam int unsigned CYCLE_CAP  = 400000;
	localparam int unsigned RAND_BEATS = 400;
	localparam logic [1:0]  OP_UNUSED  = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        quiet;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;
	int unsigned beats_sent = 0;
	int unsigned rand_beats = 0;
	int unsigned sessions = 0;

	tsa_in_if  frame ();
	tsa_out_if result ();

	threshold_sweep_autocalibrator_unit #(
		.SWEEP_STEP(STEP)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.frame (frame),
		.result(result)
	);

	tsa_calib_checker #(
		.SWEEP_STEP(STEP)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.result    (result),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$error("cycle limit reached with %0d results outstanding", pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Result receiver: random stalls unless in a quiet stretch
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < 20) begin
			stall_left <= pick_gap();
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	function automatic item_t mk(input logic [1:0] op, input logic card, input logic crc,
		input logic [TH_W-1:0] cur, input logic [TH_W-1:0] fn);
		item_t it;
		it.op = op;
		it.from_card = card;
		it.crc_ok = crc;
		it.current_threshold = cur;
		it.noise_level = fn;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_beat(input item_t it);
		int unsigned gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			frame.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame.op <= it.op;
		frame.from_card <= it.from_card;
		frame.crc_ok <= it.crc_ok;
		frame.current_threshold <= it.current_threshold;
		frame.noise_level <= it.noise_level;
		frame.valid <= 1'b1;
		do @(posedge clk); while (!frame.ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [TH_W-1:0] rand12();
		return TH_W'($urandom_range(0, 4095));
	endfunction

	task automatic send_noise();
		send_beat(mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), rand12(), rand12()));
	endtask

	// One calibration: start, first frame, then rounds that follow the sweep, sometimes a timeout
	task automatic run_session();
		int unsigned fn;
		int unsigned lo;
		int unsigned hi;
		int unsigned rounds;
		int unsigned sw;
		int unsigned win_lo;
		int unsigned win_hi;
		int unsigned r;
		int unsigned k;
		logic [TH_W-1:0] cur;
		logic good;

		r = $urandom_range(0, 99);
		if (r < 5)
			fn = 0;
		else if (r < 10)
			fn = $urandom_range(3000, 4095);
		else if (r < 15)
			fn = $urandom_range(1, 40);
		else
			fn = $urandom_range(60, 700);
		lo = fn >> 1;
		hi = fn + (fn >> 1);
		if (lo >= hi) begin
			lo = 0;
			hi = 4095;
		end
		rounds = (hi - lo + STEP - 1) / STEP;
		win_lo = $urandom_range(lo, hi);
		win_hi = win_lo + $urandom_range(0, 300);

		send_beat(mk(OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			rand12(), rand12()));
		send_beat(mk(OP_FRAME, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			rand12(), TH_W'(fn)));
		rand_beats += 2;
		sw = lo;
		for (k = 0; k < rounds + 1; k++) begin
			cur = (sw > 4095) ? TH_MAX : TH_W'(sw);
			if ($urandom_range(0, 9) == 0)
				cur = rand12();
			good = (sw >= win_lo && sw <= win_hi);
			if ($urandom_range(0, 9) == 0)
				good = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_beat(mk(OP_FRAME, 1'b0, 1'($urandom_range(0, 1)), cur, TH_W'(fn)));
				send_beat(mk(OP_FRAME, 1'b1, good, cur, TH_W'(fn)));
				rand_beats += 2;
			end else if (r < 85) begin
				// Reader frame with no card reply
				send_beat(mk(OP_FRAME, 1'b0, 1'($urandom_range(0, 1)), cur, TH_W'(fn)));
				rand_beats++;
			end else if (r < 95) begin
				send_beat(mk(OP_FRAME, 1'b1, good, cur, TH_W'(fn)));
				rand_beats++;
			end else begin
				send_noise();
				rand_beats++;
			end
			sw = sw + STEP;
		end
		if ($urandom_range(0, 19) == 0) begin
			send_beat(mk(OP_TIMEOUT, 1'b0, 1'b0, rand12(), rand12()));
			rand_beats++;
		end
		sessions++;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		frame.valid = 1'b0;
		frame.op = OP_FRAME;
		frame.from_card = 1'b0;
		frame.crc_ok = 1'b0;
		frame.current_threshold = '0;
		frame.noise_level = '0;
		result.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: idle frames, unused op, timeout, ranges and sweep endings
		send_beat(mk(OP_FRAME, 1'b1, 1'b1, TH_MAX, TH_MAX));
		send_beat(mk(OP_UNUSED, 1'b1, 1'b1, TH_MAX, TH_MAX));
		send_beat(mk(OP_TIMEOUT, 1'b0, 1'b0, 12'd0, 12'd0));
		send_beat(mk(OP_START, 1'b0, 1'b0, 12'd0, 12'd0));
		send_beat(mk(OP_FRAME, 1'b1, 1'b0, TH_MAX, 12'd0));
		send_beat(mk(OP_FRAME, 1'b1, 1'b1, TH_MAX, 12'd0));
		send_beat(mk(OP_FRAME, 1'b0, 1'b0, 12'd0, 12'd0));
		send_beat(mk(OP_FRAME, 1'b0, 1'b1, 12'd30, 12'd0));
		send_beat(mk(OP_TIMEOUT, 1'b0, 1'b0, 12'd0, 12'd0));
		send_beat(mk(OP_START, 1'b0, 1'b0, 12'd0, 12'd0));
		send_beat(mk(OP_FRAME, 1'b0, 1'b0, 12'd0, TH_MAX));
		send_beat(mk(OP_FRAME, 1'b1, 1'b1, 12'd0, TH_MAX));
		send_beat(mk(OP_START, 1'b0, 1'b0, 12'd0, 12'd0));
		send_beat(mk(OP_FRAME, 1'b1, 1'b0, 12'd2000, 12'd60));
		send_beat(mk(OP_FRAME, 1'b1, 1'b0, 12'd80, 12'd60));
		send_beat(mk(OP_FRAME, 1'b1, 1'b0, 12'd130, 12'd60));
		send_beat(mk(OP_START, 1'b0, 1'b0, 12'd0, 12'd0));
		send_beat(mk(OP_FRAME, 1'b0, 1'b0, 12'd1234, 12'd100));
		send_beat(mk(OP_FRAME, 1'b1, 1'b1, 12'd100, 12'd100));
		send_beat(mk(OP_FRAME, 1'b0, 1'b0, 12'd100, 12'd100));
		send_beat(mk(OP_FRAME, 1'b0, 1'b0, 12'd3000, 12'd100));
		send_beat(mk(OP_START, 1'b0, 1'b0, 12'd0, 12'd0));
		send_beat(mk(OP_FRAME, 1'b0, 1'b0, 12'd0, 12'd1));
		send_beat(mk(OP_FRAME, 1'b1, 1'b1, TH_MAX, 12'd1));

		// Hold off until everything is answered
		frame.valid <= 1'b0;
		drain();

		while (rand_beats < RAND_BEATS) begin
			quiet = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				frame.valid <= 1'b0;
				drain();
			end
			run_session();
		end
		quiet = 1'b0;
		frame.valid <= 1'b0;
		drain();
		repeat (10) @(negedge clk);

		$display("Covered %0d frame beats in %0d random sessions plus directed cases,",
			beats_sent, sessions);
		$display("with random gaps and stalls on both channels.");
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tsa_pkg.sv
rtl/core/tsa_in_if.sv
rtl/core/tsa_out_if.sv
rtl/core/tsa_engine.sv
rtl/core/threshold_sweep_autocalibrator_unit.sv
test/tsa_calib_checker.sv
test/threshold_sweep_autocalibrator_unit_test.sv
